// ----- hdl/wsrd_pkg.sv -----
// wsrd_pkg: shared widths, request and register codes, and the
// controller/datapath command and status structs of the ring deque.
// No dependencies.
package wsrd_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int REQ_TYPE_W = 3;
   localparam int ID_W       = 64;
   localparam int DATA_W     = 64;
   localparam int FILL_W     = 7;
   localparam int COUNT_W    = 32;
   localparam int CAP_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_STEAL   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_CREDIT  = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] OP_STATUS  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEAL_ENABLE   = 1'd1;

   typedef struct packed {
      logic accept;
      logic load_rdata;
   } wsrd_cmd_type;

   typedef struct packed {
      logic needs_read;
   } wsrd_stat_type;

endpackage

// ----- hdl/wsrd_if.sv -----
// wsrd_req_if and wsrd_rsp_if: valid/ready channels of the ring deque.
// Depends on wsrd_pkg for field widths.
interface wsrd_req_if;
   logic                               valid;
   logic                               ready;
   logic [wsrd_pkg::REQ_TYPE_W-1:0]    req_type;
   logic [wsrd_pkg::ID_W-1:0]          in_id;
   logic [wsrd_pkg::DATA_W-1:0]        in_data;

   modport source (output valid, output req_type, output in_id, output in_data,
                   input ready);
   modport sink (input valid, input req_type, input in_id, input in_data,
                 output ready);
endinterface

interface wsrd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            ok;
   logic [wsrd_pkg::ID_W-1:0]       out_id;
   logic [wsrd_pkg::DATA_W-1:0]     out_data;
   logic [wsrd_pkg::FILL_W-1:0]     fill_count;
   logic                            is_empty;
   logic                            is_full;
   logic [wsrd_pkg::COUNT_W-1:0]    from_count;
   logic [wsrd_pkg::COUNT_W-1:0]    to_count;

   modport source (output valid, output ok, output out_id, output out_data,
                   output fill_count, output is_empty, output is_full,
                   output from_count, output to_count, input ready);
   modport sink (input valid, input ok, input out_id, input out_data,
                 input fill_count, input is_empty, input is_full,
                 input from_count, input to_count, output ready);
endinterface

// ----- hdl/wsrd_ram.sv -----
// wsrd_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module wsrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/wsrd_ctrl.sv -----
// wsrd_ctrl: handshake controller of the ring deque; owns the result valid
// and waits in a read state for slot reads. Depends on wsrd_pkg.
module wsrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  wsrd_pkg::wsrd_stat_type stat,
   output wsrd_pkg::wsrd_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cmd.accept     = accept;
   assign cmd.load_rdata = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // slot reads land in the following cycle, so wait in ST_READ
               rsp_valid_in = !stat.needs_read;
               state_in     = stat.needs_read ? ST_READ : ST_IDLE;
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_read_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result valid while slot read pending");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.needs_read) |=> (state_ff == ST_READ) && !rsp_valid_ff)
      else $error("slot read not followed by read state");

endmodule

// ----- hdl/wsrd_dp.sv -----
// wsrd_dp: datapath of the ring deque: config registers, head/tail pointers,
// fill level, steal counters, slot memory and result register.
// Depends on wsrd_pkg and wsrd_ram.
module wsrd_dp #(
   parameter int DEPTH = wsrd_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [wsrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wsrd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [wsrd_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [wsrd_pkg::ID_W-1:0]          in_id,
   input  logic [wsrd_pkg::DATA_W-1:0]        in_data,
   input  wsrd_pkg::wsrd_cmd_type             cmd,
   output wsrd_pkg::wsrd_stat_type            stat,
   output logic                               ok,
   output logic [wsrd_pkg::ID_W-1:0]          out_id,
   output logic [wsrd_pkg::DATA_W-1:0]        out_data,
   output logic [wsrd_pkg::FILL_W-1:0]        fill_count,
   output logic                               is_empty,
   output logic                               is_full,
   output logic [wsrd_pkg::COUNT_W-1:0]       from_count,
   output logic [wsrd_pkg::COUNT_W-1:0]       to_count
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CMP_W  = (PTR_W + 1 > wsrd_pkg::CAP_W) ? PTR_W + 1 : wsrd_pkg::CAP_W;
   localparam int SLOT_W = wsrd_pkg::ID_W + wsrd_pkg::DATA_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
   localparam logic [wsrd_pkg::CAP_W-1:0] CAP_RESET =
      (DEPTH < 64) ? wsrd_pkg::CAP_W'(DEPTH) : wsrd_pkg::CAP_W'(64);

   logic [wsrd_pkg::CAP_W-1:0]   cap_ff;
   logic                         steal_en_ff;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic [wsrd_pkg::FILL_W-1:0]  occ_ff, occ_in;
   logic [wsrd_pkg::COUNT_W-1:0] lost_ff, lost_in;
   logic [wsrd_pkg::COUNT_W-1:0] gained_ff, gained_in;

   logic                         ok_ff, ok_in;
   logic [wsrd_pkg::ID_W-1:0]    out_id_ff;
   logic [wsrd_pkg::DATA_W-1:0]  out_data_ff;
   logic [wsrd_pkg::FILL_W-1:0]  fill_ff;
   logic                         empty_ff, full_ff;
   logic [wsrd_pkg::COUNT_W-1:0] from_ff, to_ff;

   logic [CMP_W-1:0]  cap_raw, cap_eff, occ_ext, occ_in_ext, head_inc, tail_inc;
   logic              q_full, q_empty;
   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  rd_addr, steal_slot, head_wrap, tail_wrap;
   logic [SLOT_W-1:0] rd_slot;

   // capacity of zero acts as one, above depth acts as depth
   always_comb begin
      cap_raw = CMP_W'(cap_ff);
      if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > DEPTH_C) begin
         cap_eff = DEPTH_C;
      end else begin
         cap_eff = cap_raw;
      end
   end

   assign occ_ext  = CMP_W'(occ_ff);
   assign q_full   = (occ_ext >= cap_eff);
   assign q_empty  = (occ_ff == '0);
   assign head_inc = CMP_W'(head_ff) + CMP_W'(1);
   assign tail_inc = CMP_W'(tail_ff) + CMP_W'(1);
   assign head_wrap  = (head_inc == cap_eff) ? '0 : head_inc[PTR_W-1:0];
   assign tail_wrap  = (tail_inc == cap_eff) ? '0 : tail_inc[PTR_W-1:0];
   assign steal_slot = (tail_ff == '0) ? PTR_W'(cap_eff - CMP_W'(1))
                                       : tail_ff - PTR_W'(1);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      lost_in   = lost_ff;
      gained_in = gained_ff;
      ok_in     = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      unique case (req_type)
         wsrd_pkg::OP_ENQUEUE: begin
            if (!q_full) begin
               wr_en   = 1'b1;
               tail_in = tail_wrap;
               occ_in  = occ_ff + wsrd_pkg::FILL_W'(1);
               ok_in   = 1'b1;
            end
         end
         wsrd_pkg::OP_DEQUEUE: begin
            if (!q_empty) begin
               rd_en   = 1'b1;
               head_in = head_wrap;
               occ_in  = occ_ff - wsrd_pkg::FILL_W'(1);
               ok_in   = 1'b1;
            end
         end
         wsrd_pkg::OP_PEEK: begin
            if (!q_empty) begin
               rd_en = 1'b1;
               ok_in = 1'b1;
            end
         end
         wsrd_pkg::OP_STEAL: begin
            // newest item sits just below the tail
            if (steal_en_ff && !q_empty) begin
               rd_en   = 1'b1;
               rd_addr = steal_slot;
               tail_in = steal_slot;
               occ_in  = occ_ff - wsrd_pkg::FILL_W'(1);
               lost_in = lost_ff + wsrd_pkg::COUNT_W'(1);
               ok_in   = 1'b1;
            end
         end
         wsrd_pkg::OP_CREDIT: begin
            gained_in = gained_ff + wsrd_pkg::COUNT_W'(1);
            ok_in     = 1'b1;
         end
         wsrd_pkg::OP_STATUS: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign occ_in_ext      = CMP_W'(occ_in);
   assign stat.needs_read = rd_en;

   wsrd_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_en),
      .wr_addr (tail_ff),
      .wr_data ({in_id, in_data}),
      .rd_en   (cmd.accept && rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_RESET;
         steal_en_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         lost_ff     <= '0;
         gained_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            wsrd_pkg::CSR_QUEUE_CAPACITY: begin
               // new capacity empties the queue, counters kept
               cap_ff  <= csr_wdata;
               head_ff <= '0;
               tail_ff <= '0;
               occ_ff  <= '0;
            end
            wsrd_pkg::CSR_STEAL_ENABLE: begin
               steal_en_ff <= csr_wdata[0];
            end
            default: begin
               steal_en_ff <= steal_en_ff;
            end
         endcase
      end else if (cmd.accept) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         lost_ff   <= lost_in;
         gained_ff <= gained_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ok_ff       <= ok_in;
         out_id_ff   <= '0;
         out_data_ff <= '0;
         fill_ff     <= occ_in;
         empty_ff    <= (occ_in == '0);
         full_ff     <= (occ_in_ext >= cap_eff);
         from_ff     <= lost_in;
         to_ff       <= gained_in;
      end else if (cmd.load_rdata) begin
         out_id_ff   <= rd_slot[SLOT_W-1:wsrd_pkg::DATA_W];
         out_data_ff <= rd_slot[wsrd_pkg::DATA_W-1:0];
      end
   end

   assign ok         = ok_ff;
   assign out_id     = out_id_ff;
   assign out_data   = out_data_ff;
   assign fill_count = fill_ff;
   assign is_empty   = empty_ff;
   assign is_full    = full_ff;
   assign from_count = from_ff;
   assign to_count   = to_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ext <= cap_eff)
      else $error("fill level above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(head_ff) < cap_eff)
      else $error("head pointer outside ring");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(tail_ff) < cap_eff)
      else $error("tail pointer outside ring");

endmodule

// ----- hdl/work_stealing_ring_deque.sv -----
// work_stealing_ring_deque: bounded ring work queue of id/data pairs.
// Depends on wsrd_pkg, wsrd_if, wsrd_ctrl, wsrd_dp and wsrd_ram.
//
// Usage:
//   req_ch carries one request per item: req_type (enqueue, dequeue, peek,
//   steal, credit, status) with in_id and in_data used by enqueue.
//   rsp_ch returns exactly one result per request, in order: ok, the item
//   taken or seen (zero otherwise), fill level, empty/full flags and the
//   two wrapping steal counters.
//   csr_we/csr_index/csr_wdata write queue_capacity (empties the queue) and
//   steal_enable; write only while no request is in flight.
// Timing:
//   enqueue, credit, status and failed requests: result valid in the cycle
//   after acceptance, one item per cycle while rsp_ch.ready stays high.
//   dequeue, peek and successful steal: result valid after the read state,
//   the slot passing through the registered read port of the slot memory
//   and then the result register; no new request is taken in the read state.
// Reset: queue empty, counters zero, capacity min(64, DEPTH), stealing off.
//   Slot memory is not cleared; only written slots are ever read.
// Stall: the result register holds while rsp_ch.ready is low and
//   req_ch.ready drops until the result is taken.
module work_stealing_ring_deque #(
   parameter int DEPTH = wsrd_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wsrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsrd_pkg::CSR_DATA_W-1:0] csr_wdata,
   wsrd_req_if.sink                        req_ch,
   wsrd_rsp_if.source                      rsp_ch
);

   wsrd_pkg::wsrd_cmd_type  cmd;
   wsrd_pkg::wsrd_stat_type stat;

   wsrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wsrd_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_type   (req_ch.req_type),
      .in_id      (req_ch.in_id),
      .in_data    (req_ch.in_data),
      .cmd        (cmd),
      .stat       (stat),
      .ok         (rsp_ch.ok),
      .out_id     (rsp_ch.out_id),
      .out_data   (rsp_ch.out_data),
      .fill_count (rsp_ch.fill_count),
      .is_empty   (rsp_ch.is_empty),
      .is_full    (rsp_ch.is_full),
      .from_count (rsp_ch.from_count),
      .to_count   (rsp_ch.to_count)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for work_stealing_ring_deque.
// Depends on wsrd_pkg, wsrd_if and the deque RTL; predicts every result
// in-line and checks it field by field against the response channel.
module tb_top;

   localparam int RING_DEPTH   = wsrd_pkg::DEPTH_DEFAULT;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 8;

   // request codes the block must refuse
   localparam logic [wsrd_pkg::REQ_TYPE_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [wsrd_pkg::REQ_TYPE_W-1:0] OP_UNDEF_HI = 3'd7;

   typedef struct {
      logic                          ok;
      logic [wsrd_pkg::ID_W-1:0]     out_id;
      logic [wsrd_pkg::DATA_W-1:0]   out_data;
      logic [wsrd_pkg::FILL_W-1:0]   fill_count;
      logic                          is_empty;
      logic                          is_full;
      logic [wsrd_pkg::COUNT_W-1:0]  from_count;
      logic [wsrd_pkg::COUNT_W-1:0]  to_count;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_we;
   logic [wsrd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wsrd_pkg::CSR_DATA_W-1:0] csr_wdata;

   wsrd_req_if req_if ();
   wsrd_rsp_if rsp_if ();

   work_stealing_ring_deque dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   always #10 clock = ~clock;

   // shadow copy of the deque
   logic [wsrd_pkg::ID_W-1:0]    ring_id   [RING_DEPTH];
   logic [wsrd_pkg::DATA_W-1:0]  ring_data [RING_DEPTH];
   logic [5:0]                   head;
   logic [5:0]                   tail;
   logic [wsrd_pkg::FILL_W-1:0]  occ;
   logic [wsrd_pkg::COUNT_W-1:0] lost_cnt;
   logic [wsrd_pkg::COUNT_W-1:0] gained_cnt;
   logic [wsrd_pkg::CAP_W-1:0]   cap_reg;
   logic                         steal_en;

   deque_result_type pending_results[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[work_stealing_ring_deque] ERROR");
         $finish;
      end
   end

   function automatic int ring_cap();
      int c;
      c = int'(cap_reg);
      if (c == 0) c = 1;
      if (c > RING_DEPTH) c = RING_DEPTH;
      return c;
   endfunction

   function automatic deque_result_type predict_deque_result(
         input logic [wsrd_pkg::REQ_TYPE_W-1:0] op,
         input logic [wsrd_pkg::ID_W-1:0]       id,
         input logic [wsrd_pkg::DATA_W-1:0]     data);
      deque_result_type res;
      int cap;
      int h;
      int t;
      int s;
      cap = ring_cap();
      h = head % cap;
      t = tail % cap;
      res = '{default: '0};
      case (op)
         wsrd_pkg::OP_ENQUEUE: begin
            if (occ < cap) begin
               ring_id[t] = id;
               ring_data[t] = data;
               tail = 6'((t + 1) % cap);
               occ = occ + wsrd_pkg::FILL_W'(1);
               res.ok = 1'b1;
            end
         end
         wsrd_pkg::OP_DEQUEUE: begin
            if (occ != 0) begin
               res.out_id = ring_id[h];
               res.out_data = ring_data[h];
               head = 6'((h + 1) % cap);
               occ = occ - wsrd_pkg::FILL_W'(1);
               res.ok = 1'b1;
            end
         end
         wsrd_pkg::OP_PEEK: begin
            if (occ != 0) begin
               res.out_id = ring_id[h];
               res.out_data = ring_data[h];
               res.ok = 1'b1;
            end
         end
         wsrd_pkg::OP_STEAL: begin
            if (steal_en && occ != 0) begin
               // newest item sits just behind the tail
               s = (t + cap - 1) % cap;
               res.out_id = ring_id[s];
               res.out_data = ring_data[s];
               tail = 6'(s);
               occ = occ - wsrd_pkg::FILL_W'(1);
               lost_cnt = lost_cnt + wsrd_pkg::COUNT_W'(1);
               res.ok = 1'b1;
            end
         end
         wsrd_pkg::OP_CREDIT: begin
            gained_cnt = gained_cnt + wsrd_pkg::COUNT_W'(1);
            res.ok = 1'b1;
         end
         wsrd_pkg::OP_STATUS: res.ok = 1'b1;
         default: ;
      endcase
      res.fill_count = occ;
      res.is_empty = (occ == 0);
      res.is_full = (occ >= cap);
      res.from_count = lost_cnt;
      res.to_count = gained_cnt;
      return res;
   endfunction

   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void match_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_result();
      deque_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t result with no item outstanding, expected none actual fill %0h",
                  $time, rsp_if.fill_count);
         fail_count++;
         return;
      end
      want = pending_results.pop_front();
      match_field("ok", 64'(want.ok), 64'(rsp_if.ok));
      match_field("out_id", want.out_id, rsp_if.out_id);
      match_field("out_data", want.out_data, rsp_if.out_data);
      match_field("fill_count", 64'(want.fill_count), 64'(rsp_if.fill_count));
      match_field("is_empty", 64'(want.is_empty), 64'(rsp_if.is_empty));
      match_field("is_full", 64'(want.is_full), 64'(rsp_if.is_full));
      match_field("from_count", 64'(want.from_count), 64'(rsp_if.from_count));
      match_field("to_count", 64'(want.to_count), 64'(rsp_if.to_count));
   endtask

   // response side: sample at the edge, then pick the next ready level
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.ready === 1'b1 && rsp_if.valid !== 1'b0) check_result();
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) hold = pick_gap(1'b1);
         end
      end
   end

   // valid stays high after acceptance so back-to-back items need no toggle
   task automatic push_request(input logic [wsrd_pkg::REQ_TYPE_W-1:0] op,
                               input logic [wsrd_pkg::ID_W-1:0]       id,
                               input logic [wsrd_pkg::DATA_W-1:0]     data);
      int gap;
      gap = pick_gap(req_gaps_on);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= op;
      req_if.in_id <= id;
      req_if.in_data <= data;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      pending_results.push_back(predict_deque_result(op, id, data));
   endtask

   task automatic end_phase();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [wsrd_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [wsrd_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == wsrd_pkg::CSR_QUEUE_CAPACITY) begin
         cap_reg = value;
         head = '0;
         tail = '0;
         occ = '0;
      end else begin
         steal_en = value[0];
      end
      @(posedge clock);
   endtask

   task automatic set_config(input logic [wsrd_pkg::CAP_W-1:0] cap, input logic en);
      logic [wsrd_pkg::CSR_DATA_W-1:0] steal_word;
      end_phase();
      write_csr(wsrd_pkg::CSR_QUEUE_CAPACITY, cap);
      // upper bits of the steal register are don't-care
      steal_word = wsrd_pkg::CSR_DATA_W'($urandom_range(0, 127));
      steal_word[0] = en;
      write_csr(wsrd_pkg::CSR_STEAL_ENABLE, steal_word);
   endtask

   // swings between filling and draining so full and empty are both reached
   task automatic run_traffic(input int n);
      int r;
      bit filling;
      logic [wsrd_pkg::REQ_TYPE_W-1:0] op;
      filling = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if (occ >= ring_cap()) filling = 1'b0;
         else if (occ == 0) filling = 1'b1;
         r = $urandom_range(0, 99);
         if (r < (filling ? 65 : 20)) begin
            op = wsrd_pkg::OP_ENQUEUE;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40) op = wsrd_pkg::OP_DEQUEUE;
            else if (r < 55) op = wsrd_pkg::OP_PEEK;
            else if (r < 75) op = wsrd_pkg::OP_STEAL;
            else if (r < 85) op = wsrd_pkg::OP_CREDIT;
            else if (r < 95) op = wsrd_pkg::OP_STATUS;
            else op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
         end
         push_request(op, rand_word(), rand_word());
      end
   endtask

   task automatic test_empty_requests();
      push_request(wsrd_pkg::OP_DEQUEUE, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_PEEK, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_STEAL, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_STATUS, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_CREDIT, rand_word(), rand_word());
      push_request(OP_UNDEF_LO, rand_word(), rand_word());
      push_request(OP_UNDEF_HI, rand_word(), rand_word());
   endtask

   task automatic test_field_extremes();
      push_request(wsrd_pkg::OP_ENQUEUE, '1, '1);
      push_request(wsrd_pkg::OP_ENQUEUE, '0, '0);
      push_request(wsrd_pkg::OP_ENQUEUE, 64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F);
      push_request(wsrd_pkg::OP_PEEK, '0, '0);
      // stealing still off, item present
      push_request(wsrd_pkg::OP_STEAL, '0, '0);
      repeat (3) push_request(wsrd_pkg::OP_DEQUEUE, '1, '1);
   endtask

   task automatic test_single_slot();
      set_config(7'd1, 1'b1);
      push_request(wsrd_pkg::OP_ENQUEUE, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_ENQUEUE, rand_word(), rand_word());
      push_request(wsrd_pkg::OP_STEAL, '0, '0);
      push_request(wsrd_pkg::OP_STEAL, '0, '0);
      push_request(wsrd_pkg::OP_CREDIT, '0, '0);
   endtask

   task automatic test_full_depth();
      // above the built depth the ring acts as full depth
      set_config(7'd127, 1'b1);
      run_traffic(400);
      set_config(7'd64, 1'b0);
      run_traffic(400);
   endtask

   task automatic test_small_rings();
      // zero capacity acts as one slot
      set_config(7'd0, 1'($urandom_range(0, 1)));
      run_traffic(150);
      set_config(7'd1, 1'($urandom_range(0, 1)));
      run_traffic(150);
      set_config(7'd2, 1'($urandom_range(0, 1)));
      run_traffic(150);
   endtask

   task automatic test_random_settings();
      repeat (5) begin
         set_config(wsrd_pkg::CAP_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         run_traffic(150);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= wsrd_pkg::CSR_QUEUE_CAPACITY;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.req_type <= wsrd_pkg::OP_STATUS;
      req_if.in_id <= '0;
      req_if.in_data <= '0;
      head = '0;
      tail = '0;
      occ = '0;
      lost_cnt = '0;
      gained_cnt = '0;
      cap_reg = wsrd_pkg::CAP_W'(RING_DEPTH < 64 ? RING_DEPTH : 64);
      steal_en = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_requests();
      test_field_extremes();
      test_single_slot();
      test_full_depth();
      test_small_rings();
      test_random_settings();

      end_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("[work_stealing_ring_deque] OK");
      end else begin
         $display("[work_stealing_ring_deque] ERROR");
      end
      $finish;
   end

endmodule
